// ----- rtl/core/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Types and codes shared by the sorted priority queue modules.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic               opcode;
		logic signed [31:0] item_value;
		logic        [15:0] item_priority;
	} in_t;

	typedef struct packed {
		logic        [1:0]  status;
		logic signed [31:0] out_value;
		logic        [15:0] out_priority;
		logic        [4:0]  occupancy;
	} out_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic compare;
		logic update;
	} dp_cmd_t;

endpackage

// ----- rtl/core/spq_ctrl.sv -----
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer: takes one transaction, steps the datapath through compare and
// update, and raises the result strobe.
// ----------------------------------------------------------------------------
module spq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	output logic             done,
	output spq_pkg::dp_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_CMP  = 3'b010,
		S_UPD  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   done_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_nxt = S_CMP;
			end
			S_CMP: begin
				state_nxt = S_UPD;
			end
			S_UPD: begin
				state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= (state_q == S_UPD);
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign cmd.load    = (state_q == S_IDLE) && start;
	assign cmd.compare = (state_q == S_CMP);
	assign cmd.update  = (state_q == S_UPD);

endmodule

// ----- rtl/core/spq_dp.sv -----
// ----------------------------------------------------------------------------
// spq_dp
// Sorted shift register array: every entry compares its own priority with
// the incoming one, then each entry holds, takes the new entry, or takes a
// neighbor in a single shift.
// ----------------------------------------------------------------------------
module spq_dp #(
	parameter int CAPACITY = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  spq_pkg::dp_cmd_t cmd,
	input  spq_pkg::in_t     item,
	output spq_pkg::out_t    result
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	spq_pkg::in_t       item_q;
	spq_pkg::out_t      result_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   cnt_nxt;
	logic signed [31:0] val_q [CAPACITY];
	logic        [15:0] pri_q [CAPACITY];
	logic               ge_s1 [CAPACITY];   // entry valid and priority >= new one

	logic is_ins;
	logic is_full;
	logic is_empty;
	logic ins_ok;
	logic rem_ok;

	assign is_ins   = (item_q.opcode == spq_pkg::OP_INSERT);
	assign is_full  = (cnt_q == CNT_W'(CAPACITY));
	assign is_empty = (cnt_q == '0);
	assign ins_ok   = is_ins && !is_full;
	assign rem_ok   = !is_ins && !is_empty;

	always_comb begin
		cnt_nxt = cnt_q;
		if (ins_ok) cnt_nxt = cnt_q + CNT_W'(1);
		else if (rem_ok) cnt_nxt = cnt_q - CNT_W'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.update) begin
			cnt_q <= cnt_nxt;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_ent
		logic signed [31:0] ins_v;
		logic        [15:0] ins_p;
		logic signed [31:0] nxt_v;
		logic        [15:0] nxt_p;

		// insert slot is the first entry whose predecessor stays put
		if (i == 0) begin : g_head
			assign ins_v = item_q.item_value;
			assign ins_p = item_q.item_priority;
		end else begin : g_body
			assign ins_v = ge_s1[i-1] ? item_q.item_value    : val_q[i-1];
			assign ins_p = ge_s1[i-1] ? item_q.item_priority : pri_q[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign nxt_v = val_q[i];
			assign nxt_p = pri_q[i];
		end else begin : g_mid
			assign nxt_v = val_q[i+1];
			assign nxt_p = pri_q[i+1];
		end

		always_ff @(posedge clk) begin
			if (cmd.compare) begin
				ge_s1[i] <= (CNT_W'(i) < cnt_q) && (pri_q[i] >= item_q.item_priority);
			end
		end

		always_ff @(posedge clk) begin
			if (cmd.update && ins_ok && !ge_s1[i]) begin
				val_q[i] <= ins_v;
				pri_q[i] <= ins_p;
			end else if (cmd.update && rem_ok) begin
				val_q[i] <= nxt_v;
				pri_q[i] <= nxt_p;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			result_q.status       <= rem_ok ? spq_pkg::ST_OK :
			                         ins_ok ? spq_pkg::ST_OK :
			                         is_ins ? spq_pkg::ST_FULL : spq_pkg::ST_EMPTY;
			result_q.out_value    <= rem_ok ? val_q[0] : 32'sd0;
			result_q.out_priority <= rem_ok ? pri_q[0] : 16'd0;
			result_q.occupancy    <= 5'(cnt_nxt);
		end
	end

	assign result = result_q;

endmodule

// ----- rtl/core/sorted_priority_queue_unit.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Bounded priority queue held sorted in a shift register array.
// ----------------------------------------------------------------------------
// After acceptance the unit steps through compare and update; done is then
// strobed in the idle cycle in which the next start can be taken, so a new
// transaction is accepted only after the last one has finished.
// Reset clears the entry count only; entry contents are not cleared.
// Results are strobed for one cycle; the receiver cannot stall.
module sorted_priority_queue_unit #(
	parameter int CAPACITY = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  spq_pkg::in_t  item,
	output logic          done,
	output spq_pkg::out_t result
);

	spq_pkg::dp_cmd_t cmd;

	spq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	spq_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.result (result)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobed while still busy");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status != spq_pkg::ST_OK)) |->
		(result.out_value == 32'sd0) && (result.out_priority == 16'd0))
		else $error("failed transaction returned a nonzero entry");

endmodule

// ----- dv/spq_order_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spq_order_checker
// Watches the command and result channels of the sorted priority queue,
// keeps its own sorted copy of the queue contents, and compares every
// strobed result against the oldest predicted one.
// ----------------------------------------------------------------------------
module spq_order_checker #(
	parameter int CAPACITY = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          busy,
	input  spq_pkg::in_t  item,
	input  logic          done,
	input  spq_pkg::out_t result,
	output int            mismatches,
	output int            outstanding
);
	import spq_pkg::*;

	logic signed [31:0] held_value    [CAPACITY];
	logic        [15:0] held_priority [CAPACITY];
	int                 held_count;
	out_t               predicted_results [$];

	initial begin
		mismatches  = 0;
		outstanding = 0;
		held_count  = 0;
	end

	// Sorted insert behind all entries of greater or equal priority, or pop of the head.
	function automatic out_t apply_queue_op(in_t cmd);
		out_t r;
		int   slot;
		int   k;
		r        = '0;
		r.status = ST_OK;
		if (cmd.opcode == OP_INSERT) begin
			if (held_count >= CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				slot = 0;
				while (slot < held_count && held_priority[slot] >= cmd.item_priority)
					slot++;
				for (k = held_count; k > slot; k--) begin
					held_value[k]    = held_value[k - 1];
					held_priority[k] = held_priority[k - 1];
				end
				held_value[slot]    = cmd.item_value;
				held_priority[slot] = cmd.item_priority;
				held_count++;
			end
		end else begin
			if (held_count == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.out_value    = held_value[0];
				r.out_priority = held_priority[0];
				for (k = 1; k < held_count; k++) begin
					held_value[k - 1]    = held_value[k];
					held_priority[k - 1] = held_priority[k];
				end
				held_count--;
			end
		end
		r.occupancy = held_count[4:0];
		return r;
	endfunction

	function automatic void check_field(string name, logic signed [63:0] want,
			logic signed [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			held_count = 0;
			predicted_results.delete();
		end else begin
			// results first, so a new command never masks a spurious strobe
			if (done) begin
				if (predicted_results.size() == 0) begin
					$error("result strobed with no transaction outstanding");
					mismatches++;
				end else begin
					want = predicted_results.pop_front();
					check_field("status", want.status, result.status);
					check_field("out_value", want.out_value, result.out_value);
					check_field("out_priority", want.out_priority, result.out_priority);
					check_field("occupancy", want.occupancy, result.occupancy);
				end
			end
			if (start && !busy)
				predicted_results.push_back(apply_queue_op(item));
		end
		outstanding = predicted_results.size();
	end

endmodule

// ----- dv/sorted_priority_queue_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit_test
// Drives insert and remove commands into the sorted priority queue in
// random bursts: a directed opening covers empty, full, ties and field
// extremes, then random phases swing the fill level between empty and full.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit_test;
	import spq_pkg::*;

	localparam int CAPACITY = 16;
	localparam int RANDOM_ITEMS = 1800;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	in_t  item;
	logic done;
	out_t result;
	int   mismatches;
	int   outstanding;
	int   burst_left;

	sorted_priority_queue_unit #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	spq_order_checker #(
		.CAPACITY(CAPACITY)
	) checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.item        (item),
		.done        (done),
		.result      (result),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("sorted_priority_queue_unit_test: done, errors");
		$finish;
	end

	function automatic in_t make_cmd(logic op, logic signed [31:0] v, logic [15:0] p);
		in_t t;
		t.opcode        = op;
		t.item_value    = v;
		t.item_priority = p;
		return t;
	endfunction

	// Priorities mostly from a narrow band so ties are common.
	function automatic in_t make_random(int insert_pct);
		in_t t;
		t.opcode = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
		case ($urandom_range(0, 9))
			0:       t.item_value = 32'sh8000_0000;
			1:       t.item_value = 32'sh7fff_ffff;
			2:       t.item_value = -32'sd1;
			default: t.item_value = $urandom;
		endcase
		case ($urandom_range(0, 9))
			0:       t.item_priority = 16'hffff;
			1:       t.item_priority = 16'h0000;
			2, 3:    t.item_priority = 16'($urandom);
			default: t.item_priority = 16'($urandom_range(0, 7));
		endcase
		return t;
	endfunction

	task automatic send_transaction(in_t t);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		item  <= t;
		start <= 1'b1;
		do @(posedge clk); while (busy);
	endtask

	initial begin
		int sent;
		int phase_len;
		int insert_pct;
		arst_n     = 1'b0;
		start      = 1'b0;
		item       = '0;
		burst_left = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed opening
		send_transaction(make_cmd(OP_REMOVE, 32'sh7fff_ffff, 16'hffff));
		send_transaction(make_cmd(OP_INSERT, 32'sh8000_0000, 16'h0000));
		send_transaction(make_cmd(OP_INSERT, 32'sh7fff_ffff, 16'hffff));
		send_transaction(make_cmd(OP_INSERT, 32'sd0, 16'd100));
		send_transaction(make_cmd(OP_INSERT, -32'sd1, 16'd100));
		send_transaction(make_cmd(OP_INSERT, 32'sd1, 16'd100));
		send_transaction(make_cmd(OP_INSERT, 32'sd5, 16'hffff));
		send_transaction(make_cmd(OP_INSERT, 32'sd7, 16'h0000));
		for (int k = 0; k < 9; k++)
			send_transaction(make_cmd(OP_INSERT, $urandom, 16'(k * 37 + 1)));
		send_transaction(make_cmd(OP_INSERT, 32'sh5555_aaaa, 16'hffff));
		for (int k = 0; k < 5; k++)
			send_transaction(make_cmd(OP_REMOVE, $urandom, 16'($urandom)));

		// random phases pick at random between draining and filling mixes
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			phase_len = $urandom_range(20, 120);
			case ($urandom_range(0, 3))
				0:       insert_pct = 20;
				1:       insert_pct = 50;
				2:       insert_pct = 80;
				default: insert_pct = 97;
			endcase
			for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
				send_transaction(make_random(insert_pct));
				sent++;
			end
		end
		start <= 1'b0;

		wait (outstanding == 0);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("sorted_priority_queue_unit_test: done, clean");
		else
			$display("sorted_priority_queue_unit_test: done, errors");
		$finish;
	end

endmodule
